[hw/rtl/http1_request_header_parser_macros.svh]
// Assertion macros used by the request parser back end.
`ifndef HTTP1_REQUEST_HEADER_PARSER_MACROS_SVH
`define HTTP1_REQUEST_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HRP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hrp assertion failed");

`endif

[hw/rtl/hrp_pkg.sv]
// Shared types, codes and constant text for the HTTP/1 request parser.
package hrp_pkg;

    localparam int VERSION_CHARS = 8;
    localparam int NUM_METHODS   = 9;

    // byte classes
    localparam logic [2:0] CLS_OTHER  = 3'd0;
    localparam logic [2:0] CLS_METHOD = 3'd1;
    localparam logic [2:0] CLS_URI    = 3'd2;
    localparam logic [2:0] CLS_NAME   = 3'd3;
    localparam logic [2:0] CLS_VALUE  = 3'd4;
    localparam logic [2:0] CLS_BODY   = 3'd5;

    // events
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_METHOD  = 3'd1;
    localparam logic [2:0] EV_URI     = 3'd2;
    localparam logic [2:0] EV_VERSION = 3'd3;
    localparam logic [2:0] EV_NAME    = 3'd4;
    localparam logic [2:0] EV_VALUE   = 3'd5;
    localparam logic [2:0] EV_DONE    = 3'd6;
    localparam logic [2:0] EV_ERROR   = 3'd7;

    // error kinds
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_MALFORMED = 2'd1;
    localparam logic [1:0] ERR_VALUE     = 2'd2;

    // register indexes
    localparam logic [1:0] REG_URI_LIMIT   = 2'd0;
    localparam logic [1:0] REG_NAME_LIMIT  = 2'd1;
    localparam logic [1:0] REG_VALUE_LIMIT = 2'd2;

    // method indexes with special meaning
    localparam logic [3:0] METH_GET  = 4'd0;
    localparam logic [3:0] METH_HEAD = 4'd5;

    // header-name candidate bits
    localparam int HM_CL = 0;
    localparam int HM_TE = 1;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;

    typedef logic [0:7][7:0] t_meth_text;

    // padded with blanks; only positions below the length are compared
    localparam t_meth_text METH_TEXT [NUM_METHODS] = '{
        "GET     ", "POST    ", "PUT     ", "PATCH   ", "DELETE  ",
        "HEAD    ", "OPTIONS ", "CONNECT ", "TRACE   "
    };
    localparam logic [3:0] METH_LEN [NUM_METHODS] = '{
        4'd3, 4'd4, 4'd3, 4'd5, 4'd6, 4'd4, 4'd7, 4'd7, 4'd5
    };

    localparam int CL_LEN = 14;
    localparam int TE_LEN = 17;
    localparam int CK_LEN = 7;
    localparam int VER_PREFIX = 7;

    localparam logic [0:CL_LEN-1][7:0]     CL_TEXT  = "content-length";
    localparam logic [0:TE_LEN-1][7:0]     TE_TEXT  = "transfer-encoding";
    localparam logic [0:CK_LEN-1][7:0]     CK_TEXT  = "chunked";
    localparam logic [0:VER_PREFIX-1][7:0] VER_TEXT = "HTTP/1.";

    // one byte after the classifier
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] lower;
        logic       restart;
        logic       is_blank;
        logic       is_digit;
    } t_item;

    // queue to back end
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_out;

endpackage

[hw/rtl/hrp_front.sv]
// Front end: accepts bytes, classifies them and queues them for the parser.
module hrp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [7:0]      i_byte_in,
    input  logic            i_restart,
    output hrp_pkg::t_q_out o_q,
    input  logic            i_pop
);
    import hrp_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    t_item      w_cls;
    logic       w_push;

    always_comb begin
        w_cls.data     = i_byte_in;
        w_cls.restart  = i_restart;
        w_cls.is_blank = (i_byte_in == CH_SP) || (i_byte_in == CH_TAB);
        w_cls.is_digit = (i_byte_in >= 8'h30) && (i_byte_in <= 8'h39);
        w_cls.lower    = ((i_byte_in >= 8'h41) && (i_byte_in <= 8'h5A)) ?
                         (i_byte_in + 8'd32) : i_byte_in;
    end

    assign o_stall = (r_count == 2'd2);
    assign w_push  = i_valid && !o_stall;

    assign o_q.valid = (r_count != 2'd0);
    assign o_q.item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= !r_wr_ptr;
            if (i_pop)  r_rd_ptr <= !r_rd_ptr;
            case ({w_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hw/rtl/hrp_back.sv]
// Back end: parser state machine, limit registers and output register.
`include "http1_request_header_parser_macros.svh"

module hrp_back #(
    parameter int METHOD_LIMIT = 7,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hrp_pkg::t_q_out i_q,
    output logic            o_pop,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [15:0]     i_cfg_data,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_byte_out,
    output logic [2:0]      o_byte_class,
    output logic [2:0]      o_event_res,
    output logic [3:0]      o_method_index,
    output logic            o_protocol_minor,
    output logic [1:0]      o_error_kind,
    output logic [15:0]     o_token_length,
    output logic [63:0]     o_body_length,
    output logic            o_is_chunked
);
    import hrp_pkg::*;

    localparam int         CW   = COUNT_WIDTH;
    localparam logic [32:0] CMAX = (33'd1 << COUNT_WIDTH) - 33'd1;
    localparam logic [32:0] MLIM = 33'(METHOD_LIMIT);

    typedef enum logic [2:0] {
        PH_METHOD, PH_URI, PH_VERSION, PH_NAME, PH_VALUE, PH_BODY, PH_DONE, PH_ERROR
    } t_phase;

    logic [15:0] r_uri_limit, r_name_limit, r_value_limit;

    t_phase          r_phase, c_phase, n_phase;
    logic [CW-1:0]   r_fc, c_fc, n_fc;
    logic [8:0]      r_mcand, c_mcand, n_mcand;
    logic [3:0]      r_mfound, c_mfound, n_mfound;
    logic            r_vminor, c_vminor, n_vminor;
    logic            r_lcr, c_lcr, n_lcr;
    logic [1:0]      r_hmatch, c_hmatch, n_hmatch;
    logic            r_trim_st, c_trim_st, n_trim_st;
    logic [63:0]     r_len, c_len, n_len;
    logic            r_ck_seen, c_ck_seen, n_ck_seen;
    logic [3:0]      r_ck_match, c_ck_match, n_ck_match;
    logic [63:0]     r_body, c_body, n_body;
    logic [1:0]      r_err, c_err, n_err;
    logic [CW-1:0]   r_trim_len, c_trim_len, n_trim_len;
    logic [CW-1:0]   r_pend, c_pend, n_pend;

    logic            r_o_valid;
    logic [7:0]      r_o_byte;
    logic [2:0]      r_o_class, r_o_event;
    logic [3:0]      r_o_midx;
    logic            r_o_minor, r_o_chunked;
    logic [1:0]      r_o_err;
    logic [15:0]     r_o_tok;
    logic [63:0]     r_o_blen;

    logic [2:0]      n_cls, n_ev;
    logic [15:0]     n_tok;
    logic            w_bad;
    logic [1:0]      w_bad_kind;
    logic [3:0]      w_hit;
    logic            w_hit_ok;
    logic [32:0]     w_fc_w;
    logic            w_gap;
    logic [67:0]     w_len10;
    logic [63:0]     w_body_inc;
    t_item           w_it;

    assign w_it  = i_q.item;
    assign o_pop = i_q.valid && (!r_o_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uri_limit   <= 16'd8192;
            r_name_limit  <= 16'd256;
            r_value_limit <= 16'd8192;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_URI_LIMIT:   r_uri_limit   <= i_cfg_data;
                REG_NAME_LIMIT:  r_name_limit  <= i_cfg_data;
                REG_VALUE_LIMIT: r_value_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        // restart clears the parser before this byte
        if (w_it.restart) begin
            c_phase = PH_METHOD; c_fc = '0; c_mcand = '1; c_mfound = '0;
            c_vminor = 1'b0; c_lcr = 1'b0; c_hmatch = 2'b11; c_trim_st = 1'b0;
            c_len = '0; c_ck_seen = 1'b0; c_ck_match = '0; c_body = '0;
            c_err = ERR_NONE; c_trim_len = '0; c_pend = '0;
        end else begin
            c_phase = r_phase; c_fc = r_fc; c_mcand = r_mcand; c_mfound = r_mfound;
            c_vminor = r_vminor; c_lcr = r_lcr; c_hmatch = r_hmatch;
            c_trim_st = r_trim_st; c_len = r_len; c_ck_seen = r_ck_seen;
            c_ck_match = r_ck_match; c_body = r_body; c_err = r_err;
            c_trim_len = r_trim_len; c_pend = r_pend;
        end

        n_phase = c_phase; n_fc = c_fc; n_mcand = c_mcand; n_mfound = c_mfound;
        n_vminor = c_vminor; n_lcr = c_lcr; n_hmatch = c_hmatch; n_trim_st = c_trim_st;
        n_len = c_len; n_ck_seen = c_ck_seen; n_ck_match = c_ck_match; n_body = c_body;
        n_err = c_err; n_trim_len = c_trim_len; n_pend = c_pend;

        n_cls = CLS_OTHER; n_ev = EV_NONE; n_tok = '0;
        w_bad = 1'b0; w_bad_kind = ERR_MALFORMED;
        w_fc_w = 33'(c_fc);
        w_gap = (c_pend != '0);
        w_len10 = {1'b0, c_len, 3'b000} + {3'b000, c_len, 1'b0}
                + {60'd0, w_it.data - CH_ZERO};
        w_body_inc = c_body + 64'd1;

        w_hit = '0; w_hit_ok = 1'b0;
        for (int i = NUM_METHODS - 1; i >= 0; i--) begin
            if (c_mcand[i] && (w_fc_w == 33'(METH_LEN[i]))) begin
                w_hit = 4'(i); w_hit_ok = 1'b1;
            end
        end

        unique case (c_phase)
            PH_METHOD: begin
                if (w_it.data == CH_SP) begin
                    if (c_fc == '0 || !w_hit_ok) begin
                        w_bad = 1'b1;
                    end else begin
                        n_mfound = w_hit; n_ev = EV_METHOD; n_tok = 16'(c_fc);
                        n_phase = PH_URI; n_fc = '0;
                    end
                end else if (w_fc_w >= MLIM || w_fc_w >= CMAX) begin
                    w_bad = 1'b1;
                end else begin
                    for (int i = 0; i < NUM_METHODS; i++) begin
                        if (!(w_fc_w < 33'(METH_LEN[i]) &&
                              METH_TEXT[i][c_fc[2:0]] == w_it.data))
                            n_mcand[i] = 1'b0;
                    end
                    n_fc = c_fc + 1'b1; n_cls = CLS_METHOD;
                end
            end
            PH_URI: begin
                if (w_it.data == CH_SP) begin
                    if (c_fc == '0) begin
                        w_bad = 1'b1;
                    end else begin
                        n_ev = EV_URI; n_tok = 16'(c_fc); n_phase = PH_VERSION; n_fc = '0;
                    end
                end else if (w_fc_w >= 33'(r_uri_limit) || w_fc_w >= CMAX) begin
                    w_bad = 1'b1;
                end else begin
                    n_fc = c_fc + 1'b1; n_cls = CLS_URI;
                end
            end
            PH_VERSION: begin
                if (w_fc_w < 33'(VER_PREFIX)) begin
                    if (w_it.data != VER_TEXT[c_fc[2:0]]) w_bad = 1'b1;
                    else n_fc = c_fc + 1'b1;
                end else if (w_fc_w == 33'(VER_PREFIX)) begin
                    if (w_it.data != CH_ZERO && w_it.data != CH_ONE) begin
                        w_bad = 1'b1;
                    end else begin
                        n_vminor = (w_it.data == CH_ONE); n_fc = c_fc + 1'b1;
                    end
                end else if (w_fc_w == 33'(VERSION_CHARS)) begin
                    if (w_it.data != CH_CR) w_bad = 1'b1;
                    else n_fc = c_fc + 1'b1;
                end else if (w_it.data != CH_LF) begin
                    w_bad = 1'b1;
                end else begin
                    n_ev = EV_VERSION; n_tok = 16'(VERSION_CHARS); n_phase = PH_NAME;
                    n_fc = '0; n_lcr = 1'b0; n_hmatch = 2'b11;
                end
            end
            PH_NAME: begin
                if (c_fc == '0 && c_lcr) begin
                    if (w_it.data != CH_LF) begin
                        w_bad = 1'b1;
                    end else begin
                        n_lcr = 1'b0;
                        if (c_mfound == METH_GET || c_mfound == METH_HEAD || c_len == '0) begin
                            n_phase = PH_DONE; n_ev = EV_DONE;
                        end else begin
                            n_phase = PH_BODY; n_body = '0;
                        end
                    end
                end else if (c_fc == '0 && w_it.data == CH_CR) begin
                    n_lcr = 1'b1;
                end else if (w_it.data == CH_COLON) begin
                    if (c_fc == '0) begin
                        w_bad = 1'b1;
                    end else begin
                        if (w_fc_w != 33'(CL_LEN)) n_hmatch[HM_CL] = 1'b0;
                        if (w_fc_w != 33'(TE_LEN)) n_hmatch[HM_TE] = 1'b0;
                        if (n_hmatch[HM_CL]) n_len = '0;
                        n_ev = EV_NAME; n_tok = 16'(c_fc); n_phase = PH_VALUE; n_fc = '0;
                        n_trim_st = 1'b0; n_trim_len = '0; n_pend = '0;
                        n_ck_match = '0; n_lcr = 1'b0;
                    end
                end else if (w_fc_w >= 33'(r_name_limit) || w_fc_w >= CMAX) begin
                    w_bad = 1'b1;
                end else begin
                    if (!(w_fc_w < 33'(CL_LEN) && w_it.lower == CL_TEXT[c_fc[3:0]]))
                        n_hmatch[HM_CL] = 1'b0;
                    if (!(w_fc_w < 33'(TE_LEN) && w_it.lower == TE_TEXT[c_fc[4:0]]))
                        n_hmatch[HM_TE] = 1'b0;
                    n_fc = c_fc + 1'b1; n_cls = CLS_NAME;
                end
            end
            PH_VALUE: begin
                if (c_lcr) begin
                    if (w_it.data != CH_LF) begin
                        w_bad = 1'b1;
                    end else if (c_hmatch[HM_CL] && c_trim_len == '0) begin
                        w_bad = 1'b1; w_bad_kind = ERR_VALUE;
                    end else if (c_hmatch[HM_TE] &&
                                 !(c_ck_match == 4'(CK_LEN) &&
                                   33'(c_trim_len) == 33'(CK_LEN))) begin
                        w_bad = 1'b1; w_bad_kind = ERR_VALUE;
                    end else begin
                        if (c_hmatch[HM_TE]) n_ck_seen = 1'b1;
                        n_ev = EV_VALUE; n_tok = 16'(c_trim_len); n_phase = PH_NAME;
                        n_fc = '0; n_lcr = 1'b0; n_hmatch = 2'b11;
                    end
                end else if (w_it.data == CH_CR) begin
                    n_lcr = 1'b1;
                end else if (w_it.data == CH_LF) begin
                    w_bad = 1'b1;
                end else if (w_fc_w >= 33'(r_value_limit) || w_fc_w >= CMAX) begin
                    w_bad = 1'b1;
                end else begin
                    n_fc = c_fc + 1'b1; n_cls = CLS_VALUE;
                    if (w_it.is_blank) begin
                        if (c_trim_st) n_pend = c_pend + 1'b1;
                    end else begin
                        n_trim_len = c_trim_len + c_pend + 1'b1;
                        n_pend = '0; n_trim_st = 1'b1;
                        if (c_hmatch[HM_CL]) begin
                            if (!w_it.is_digit || w_gap || w_len10[67:64] != 4'd0) begin
                                w_bad = 1'b1; w_bad_kind = ERR_VALUE;
                            end else begin
                                n_len = w_len10[63:0];
                            end
                        end
                        if (c_hmatch[HM_TE]) begin
                            if (w_gap || c_ck_match >= 4'(CK_LEN) ||
                                w_it.lower != CK_TEXT[c_ck_match[2:0]])
                                n_ck_match = 4'hF;
                            else
                                n_ck_match = c_ck_match + 4'd1;
                        end
                    end
                end
            end
            PH_BODY: begin
                n_cls = CLS_BODY; n_body = w_body_inc;
                if (w_body_inc >= c_len) begin
                    n_phase = PH_DONE; n_ev = EV_DONE;
                end
            end
            default: ;
        endcase

        if (w_bad) begin
            n_phase = PH_ERROR; n_err = w_bad_kind; n_ev = EV_ERROR;
            n_cls = CLS_OTHER; n_tok = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_METHOD; r_fc <= '0; r_mcand <= '1; r_mfound <= '0;
            r_vminor <= 1'b0; r_lcr <= 1'b0; r_hmatch <= 2'b11; r_trim_st <= 1'b0;
            r_len <= '0; r_ck_seen <= 1'b0; r_ck_match <= '0; r_body <= '0;
            r_err <= ERR_NONE; r_trim_len <= '0; r_pend <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase; r_fc <= n_fc; r_mcand <= n_mcand;
                r_mfound <= n_mfound; r_vminor <= n_vminor; r_lcr <= n_lcr;
                r_hmatch <= n_hmatch; r_trim_st <= n_trim_st; r_len <= n_len;
                r_ck_seen <= n_ck_seen; r_ck_match <= n_ck_match; r_body <= n_body;
                r_err <= n_err; r_trim_len <= n_trim_len; r_pend <= n_pend;
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_o_byte    <= w_it.data;
            r_o_class   <= n_cls;
            r_o_event   <= n_ev;
            r_o_midx    <= n_mfound;
            r_o_minor   <= n_vminor;
            r_o_err     <= n_err;
            r_o_tok     <= n_tok;
            r_o_blen    <= n_len;
            r_o_chunked <= n_ck_seen;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_byte_out       = r_o_byte;
    assign o_byte_class     = r_o_class;
    assign o_event_res      = r_o_event;
    assign o_method_index   = r_o_midx;
    assign o_protocol_minor = r_o_minor;
    assign o_error_kind     = r_o_err;
    assign o_token_length   = r_o_tok;
    assign o_body_length    = r_o_blen;
    assign o_is_chunked     = r_o_chunked;

    `HRP_ASSERT_IMPLY(a_err_kind_set, i_clk, i_rst_n, r_phase == PH_ERROR, r_err != ERR_NONE)
    `HRP_ASSERT_IMPLY(a_err_event, i_clk, i_rst_n, r_o_valid && r_o_event == EV_ERROR, r_o_err != ERR_NONE)
    `HRP_ASSERT_IMPLY(a_body_len, i_clk, i_rst_n, r_phase == PH_BODY, r_len != 64'd0)
    `HRP_ASSERT_NEXT(a_pop_loads, i_clk, i_rst_n, o_pop, r_o_valid)

endmodule

[hw/rtl/http1_request_header_parser.sv]
// Top level of the HTTP/1 request header parser.
//
// Usage:
//  Input channel: one request byte per transfer (i_byte_in, i_restart) on
//  i_valid / o_stall. i_restart clears the parse state before its byte.
//  Output channel: one classified result per input byte on o_valid /
//  i_stall, in input order: byte, class, event, method, minor version,
//  error kind, token length, content length so far and chunked flag.
//  Configuration: i_cfg_we writes i_cfg_data into limit register
//  i_cfg_idx (0 URI, 1 header name, 2 header value); index 3 is ignored.
//  Write only while no byte is in flight.
// Timing:
//  One byte per cycle sustained while i_stall is low. A result passes
//  through the front-end classifier queue, then through the parser
//  step into the output register; the parser state update is a loop
//  through the state registers alone, which sets the rate.
// Reset and stall:
//  Synchronous active-low reset empties the queue, drops o_valid, sets the
//  parser to the method phase and loads the default limits. While the
//  receiver stalls the result holds; the two-entry queue takes up to two
//  more bytes, then o_stall rises.
module http1_request_header_parser #(
    parameter int METHOD_LIMIT = 7,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_in,
    input  logic        i_restart,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_byte_out,
    output logic [2:0]  o_byte_class,
    output logic [2:0]  o_event_res,
    output logic [3:0]  o_method_index,
    output logic        o_protocol_minor,
    output logic [1:0]  o_error_kind,
    output logic [15:0] o_token_length,
    output logic [63:0] o_body_length,
    output logic        o_is_chunked
);
    import hrp_pkg::*;

    t_q_out w_q;    // head of the classifier queue
    logic   w_pop;  // parser takes the head this cycle

    hrp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_byte_in (i_byte_in),
        .i_restart (i_restart),
        .o_q       (w_q),
        .i_pop     (w_pop)
    );

    hrp_back #(
        .METHOD_LIMIT (METHOD_LIMIT),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q              (w_q),
        .o_pop            (w_pop),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_byte_out       (o_byte_out),
        .o_byte_class     (o_byte_class),
        .o_event_res      (o_event_res),
        .o_method_index   (o_method_index),
        .o_protocol_minor (o_protocol_minor),
        .o_error_kind     (o_error_kind),
        .o_token_length   (o_token_length),
        .o_body_length    (o_body_length),
        .o_is_chunked     (o_is_chunked)
    );

endmodule
